FILE: sv/assert_macros.svh
// Assertion macros shared by the tile grid scan RTL.
// Needs nothing else; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge out of reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen at a rising edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: sv/tgo_pkg.sv
// Shared types, constants and helper functions of the tile grid overlap scan.
// Standalone; the front, back and top-level RTL files refer to it by scoped names.
`default_nettype none

package tgo_pkg;

    // Store geometry
    localparam int GRID_COLS     = 64;
    localparam int GRID_ROWS     = 64;
    localparam int NUM_LAYERS    = 4;
    localparam int MAX_SPAN      = 8;
    localparam int TILE_SHIFT    = 3;
    localparam int TILE_ROUND    = 4;

    // Field widths
    localparam int ID_W      = 16;
    localparam int LAYER_W   = 2;
    localparam int POS_W     = 16;
    localparam int SIZE_W    = 16;
    localparam int TPOS_W    = 6;
    localparam int CODE_W    = 8;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Derived widths
    localparam int COL_AW   = (GRID_COLS  > 1) ? $clog2(GRID_COLS)  : 1;
    localparam int ROW_AW   = (GRID_ROWS  > 1) ? $clog2(GRID_ROWS)  : 1;
    localparam int LAYER_AW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int COLS_P2  = 1 << COL_AW;
    localparam int ROWS_P2  = 1 << ROW_AW;
    localparam int ADDR_W   = LAYER_AW + ROW_AW + COL_AW;
    localparam int STORE_DEPTH = NUM_LAYERS * ROWS_P2 * COLS_P2;
    localparam int ORG_W    = POS_W - TILE_SHIFT;
    localparam int COORD_W  = ORG_W + 1;
    localparam int SPAN_W   = $clog2(MAX_SPAN + 1);

    // Queues
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PW     = $clog2(OUT_DEPTH);
    localparam int OUT_CW     = $clog2(OUT_DEPTH + 1);

    // Register reset values
    localparam logic [CFG_W-1:0] TILES_WIDE_RST = CFG_W'(64);
    localparam logic [CFG_W-1:0] TILES_HIGH_RST = CFG_W'(64);

    // Codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TILES_WIDE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TILES_HIGH = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_SCAN,
        BS_DRAIN
    } back_state_t;

    typedef struct packed {
        logic                action;
        logic [ID_W-1:0]     entity;
        logic [LAYER_W-1:0]  layer;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [SIZE_W-1:0]   rect_width;
        logic [SIZE_W-1:0]   rect_height;
        logic [TPOS_W-1:0]   tile_col;
        logic [TPOS_W-1:0]   tile_row;
        logic [CODE_W-1:0]   tile_code;
    } in_t;

    typedef struct packed {
        logic [ID_W-1:0]     hit_entity;
        logic [CODE_W-1:0]   hit_code;
        logic [TPOS_W-1:0]   hit_col;
        logic [TPOS_W-1:0]   hit_row;
        logic                last;
    } out_t;

    // Classified command between front and back
    typedef struct packed {
        logic                is_query;
        logic [ID_W-1:0]     entity;
        logic [LAYER_W-1:0]  layer;
        logic [ORG_W-1:0]    x0;
        logic [ORG_W-1:0]    y0;
        logic [SPAN_W-1:0]   sw;
        logic [SPAN_W-1:0]   sh;
        logic [TPOS_W-1:0]   wcol;
        logic [TPOS_W-1:0]   wrow;
        logic [CODE_W-1:0]   code;
    } cmd_t;

    // Tiles covered by a size in pixels, rounded to nearest, clamped.
    function automatic logic [SPAN_W-1:0] span_of(input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0]            sum;
        logic [SIZE_W-TILE_SHIFT:0] s;
        sum = {1'b0, size} + (SIZE_W+1)'(TILE_ROUND);
        s   = sum[SIZE_W:TILE_SHIFT];
        if (32'(s) > MAX_SPAN)
            return SPAN_W'(MAX_SPAN);
        return SPAN_W'(s);
    endfunction

    // Flat store address; multiplies are by powers of two.
    function automatic logic [ADDR_W-1:0] tile_addr(
        input logic [LAYER_W-1:0] layer,
        input logic [COORD_W-1:0] row,
        input logic [COORD_W-1:0] col
    );
        logic [31:0] a;
        a = (32'(layer) * 32'(ROWS_P2) + 32'(row[ROW_AW-1:0])) * 32'(COLS_P2)
            + 32'(col[COL_AW-1:0]);
        return a[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/tgo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tgo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/tgo_front.sv
// Front end: accepts input items, classifies them into commands, queues them.
// Depends on tgo_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tgo_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire tgo_pkg::in_t item,
    output      logic         full,
    input  wire logic         clearing,
    output      tgo_pkg::cmd_t cmd,
    output      logic         cmd_valid,
    input  wire logic         cmd_pop
);

    tgo_pkg::cmd_t                     q_reg [tgo_pkg::CMDQ_DEPTH];
    logic [tgo_pkg::CMDQ_PW-1:0]       wp_reg, wp_next;
    logic [tgo_pkg::CMDQ_PW-1:0]       rp_reg, rp_next;
    logic [tgo_pkg::CMDQ_CW-1:0]       cnt_reg, cnt_next;
    tgo_pkg::cmd_t                     new_cmd;
    logic                              accept;
    logic                              keep;
    logic                              enq;
    logic                              deq;

    assign full      = clearing || (cnt_reg == tgo_pkg::CMDQ_CW'(tgo_pkg::CMDQ_DEPTH));
    assign accept    = push && !full;
    assign enq       = accept && keep;
    assign cmd_valid = (cnt_reg != '0);
    assign deq       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rp_reg];

    // Classify: drop writes outside the store, queries on a missing layer or zero span
    always_comb
    begin
        new_cmd.is_query = (item.action == tgo_pkg::ACT_QUERY);
        new_cmd.entity   = item.entity;
        new_cmd.layer    = item.layer;
        new_cmd.x0       = item.pos_x[tgo_pkg::POS_W-1:tgo_pkg::TILE_SHIFT];
        new_cmd.y0       = item.pos_y[tgo_pkg::POS_W-1:tgo_pkg::TILE_SHIFT];
        new_cmd.sw       = tgo_pkg::span_of(item.rect_width);
        new_cmd.sh       = tgo_pkg::span_of(item.rect_height);
        new_cmd.wcol     = item.tile_col;
        new_cmd.wrow     = item.tile_row;
        new_cmd.code     = item.tile_code;
        if (new_cmd.is_query)
            keep = (32'(item.layer) < tgo_pkg::NUM_LAYERS)
                   && (new_cmd.sw != '0) && (new_cmd.sh != '0);
        else
            keep = (32'(item.layer) < tgo_pkg::NUM_LAYERS)
                   && (32'(item.tile_col) < tgo_pkg::GRID_COLS)
                   && (32'(item.tile_row) < tgo_pkg::GRID_ROWS);
    end

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (enq)
            wp_next = (32'(wp_reg) == tgo_pkg::CMDQ_DEPTH - 1) ? '0 : wp_reg + 1'b1;
        if (deq)
            rp_next = (32'(rp_reg) == tgo_pkg::CMDQ_DEPTH - 1) ? '0 : rp_reg + 1'b1;
        if (enq && !deq)
            cnt_next = cnt_reg + 1'b1;
        else if (deq && !enq)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            q_reg[wp_reg] <= new_cmd;
    end

    `ASSERT_NEVER(a_cmdq_overrun, clk, rst_n,
                  enq && !deq && (cnt_reg == tgo_pkg::CMDQ_CW'(tgo_pkg::CMDQ_DEPTH)),
                  "command queue written while full")
    `ASSERT_NEVER(a_accept_in_clear, clk, rst_n, accept && clearing,
                  "item accepted during store clear")
    `ASSERT_AT(a_cmdq_count, clk, rst_n,
               cnt_reg <= tgo_pkg::CMDQ_CW'(tgo_pkg::CMDQ_DEPTH),
               "command queue count out of range")

endmodule

`default_nettype wire

FILE: sv/tgo_back.sv
// Back end: clears the tile store, applies writes, scans query rectangles,
// and queues hits. Depends on tgo_pkg, tgo_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tgo_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [tgo_pkg::CFG_W-1:0]  tiles_wide,
    input  wire logic [tgo_pkg::CFG_W-1:0]  tiles_high,
    input  wire tgo_pkg::cmd_t              cmd,
    input  wire logic                       cmd_valid,
    output      logic                       cmd_pop,
    output      logic                       clearing,
    output      logic                       empty,
    input  wire logic                       pop,
    output      tgo_pkg::out_t              result
);

    tgo_pkg::back_state_t               state_reg, state_next;
    logic [tgo_pkg::ADDR_W-1:0]         clr_addr_reg, clr_addr_next;
    tgo_pkg::cmd_t                      job_reg, job_next;
    logic [tgo_pkg::SPAN_W-1:0]         ci_reg, ci_next;
    logic [tgo_pkg::SPAN_W-1:0]         ri_reg, ri_next;
    logic                               rd_vld_reg, rd_vld_next;
    logic [tgo_pkg::TPOS_W-1:0]         rd_col_reg, rd_col_next;
    logic [tgo_pkg::TPOS_W-1:0]         rd_row_reg, rd_row_next;
    logic                               pend_vld_reg, pend_vld_next;
    tgo_pkg::out_t                      pend_reg, pend_next;
    tgo_pkg::out_t                      ofifo_reg [tgo_pkg::OUT_DEPTH];
    logic [tgo_pkg::OUT_PW-1:0]         ohead_reg, ohead_next;
    logic [tgo_pkg::OUT_PW-1:0]         otail_reg, otail_next;
    logic [tgo_pkg::OUT_CW-1:0]         ocnt_reg, ocnt_next;

    logic                               ram_we;
    logic [tgo_pkg::ADDR_W-1:0]         ram_waddr;
    logic [tgo_pkg::CODE_W-1:0]         ram_wdata;
    logic                               ram_re;
    logic [tgo_pkg::ADDR_W-1:0]         ram_raddr;
    logic [tgo_pkg::CODE_W-1:0]         ram_rdata;

    logic [tgo_pkg::COORD_W-1:0]        c_cur, r_cur;
    logic                               in_grid;
    logic                               room;
    logic                               hit;
    logic                               flush;
    logic                               ofifo_push;
    tgo_pkg::out_t                      ofifo_data;
    logic                               ofifo_pop;

    tgo_ram #(
        .WIDTH (tgo_pkg::CODE_W),
        .DEPTH (tgo_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign c_cur = tgo_pkg::COORD_W'(job_reg.x0) + tgo_pkg::COORD_W'(ci_reg);
    assign r_cur = tgo_pkg::COORD_W'(job_reg.y0) + tgo_pkg::COORD_W'(ri_reg);
    assign in_grid = (32'(c_cur) < 32'(tiles_wide)) && (32'(c_cur) < tgo_pkg::GRID_COLS)
                  && (32'(r_cur) < 32'(tiles_high)) && (32'(r_cur) < tgo_pkg::GRID_ROWS);
    // Leave a slot for the read still in flight
    assign room     = (ocnt_reg <= tgo_pkg::OUT_CW'(tgo_pkg::OUT_DEPTH - 2));
    assign hit      = rd_vld_reg && (ram_rdata != '0);
    assign clearing = (state_reg == tgo_pkg::BS_CLEAR);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        job_next      = job_reg;
        ci_next       = ci_reg;
        ri_next       = ri_reg;
        cmd_pop       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = clr_addr_reg;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = tgo_pkg::tile_addr(job_reg.layer, r_cur, c_cur);
        rd_vld_next   = 1'b0;
        rd_col_next   = c_cur[tgo_pkg::TPOS_W-1:0];
        rd_row_next   = r_cur[tgo_pkg::TPOS_W-1:0];
        flush         = 1'b0;
        unique case (state_reg)
            tgo_pkg::BS_CLEAR:
            begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == tgo_pkg::ADDR_W'(tgo_pkg::STORE_DEPTH - 1))
                    state_next = tgo_pkg::BS_IDLE;
            end
            tgo_pkg::BS_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.is_query)
                    begin
                        job_next   = cmd;
                        ci_next    = '0;
                        ri_next    = '0;
                        state_next = tgo_pkg::BS_SCAN;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = tgo_pkg::tile_addr(cmd.layer,
                                                       tgo_pkg::COORD_W'(cmd.wrow),
                                                       tgo_pkg::COORD_W'(cmd.wcol));
                        ram_wdata = cmd.code;
                    end
                end
            end
            tgo_pkg::BS_SCAN:
            begin
                if (room)
                begin
                    ram_re      = in_grid;
                    rd_vld_next = in_grid;
                    if (ci_reg == job_reg.sw - 1'b1)
                    begin
                        ci_next = '0;
                        if (ri_reg == job_reg.sh - 1'b1)
                            state_next = tgo_pkg::BS_DRAIN;
                        else
                            ri_next = ri_reg + 1'b1;
                    end
                    else
                        ci_next = ci_reg + 1'b1;
                end
            end
            tgo_pkg::BS_DRAIN:
            begin
                // Wait for the last read, then release the held hit marked last
                if (!rd_vld_reg)
                begin
                    if (!pend_vld_reg)
                        state_next = tgo_pkg::BS_IDLE;
                    else if (ocnt_reg != tgo_pkg::OUT_CW'(tgo_pkg::OUT_DEPTH))
                    begin
                        flush      = 1'b1;
                        state_next = tgo_pkg::BS_IDLE;
                    end
                end
            end
            default:
                state_next = tgo_pkg::BS_IDLE;
        endcase
    end

    // Hold one hit back so the final one can carry the last mark
    always_comb
    begin
        ofifo_push    = 1'b0;
        ofifo_data    = pend_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        if (hit)
        begin
            ofifo_push           = pend_vld_reg;
            ofifo_data.last      = 1'b0;
            pend_vld_next        = 1'b1;
            pend_next.hit_entity = job_reg.entity;
            pend_next.hit_code   = ram_rdata;
            pend_next.hit_col    = rd_col_reg;
            pend_next.hit_row    = rd_row_reg;
            pend_next.last       = 1'b0;
        end
        else if (flush)
        begin
            ofifo_push      = 1'b1;
            ofifo_data.last = 1'b1;
            pend_vld_next   = 1'b0;
        end
    end

    assign empty     = (ocnt_reg == '0);
    assign ofifo_pop = pop && !empty;
    assign result    = ofifo_reg[ohead_reg];

    always_comb
    begin
        ohead_next = ohead_reg;
        otail_next = otail_reg;
        ocnt_next  = ocnt_reg;
        if (ofifo_push)
            otail_next = (32'(otail_reg) == tgo_pkg::OUT_DEPTH - 1) ? '0 : otail_reg + 1'b1;
        if (ofifo_pop)
            ohead_next = (32'(ohead_reg) == tgo_pkg::OUT_DEPTH - 1) ? '0 : ohead_reg + 1'b1;
        if (ofifo_push && !ofifo_pop)
            ocnt_next = ocnt_reg + 1'b1;
        else if (ofifo_pop && !ofifo_push)
            ocnt_next = ocnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tgo_pkg::BS_CLEAR;
            clr_addr_reg <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            ohead_reg    <= '0;
            otail_reg    <= '0;
            ocnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
            ohead_reg    <= ohead_next;
            otail_reg    <= otail_next;
            ocnt_reg     <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        ci_reg     <= ci_next;
        ri_reg     <= ri_next;
        rd_col_reg <= rd_col_next;
        rd_row_reg <= rd_row_next;
        pend_reg   <= pend_next;
        if (ofifo_push)
            ofifo_reg[otail_reg] <= ofifo_data;
    end

    `ASSERT_NEVER(a_ofifo_overrun, clk, rst_n,
                  ofifo_push && (ocnt_reg == tgo_pkg::OUT_CW'(tgo_pkg::OUT_DEPTH)),
                  "result queue written while full")
    `ASSERT_AT(a_read_from_scan, clk, rst_n,
               rd_vld_reg |-> $past(state_reg == tgo_pkg::BS_SCAN),
               "tile read outside a scan")
    `ASSERT_NEVER(a_pop_in_clear, clk, rst_n, cmd_pop && clearing,
                  "command taken during store clear")

endmodule

`default_nettype wire

FILE: sv/tile_grid_overlap_scan.sv
// Top level of the tile grid overlap scan: configuration registers and the
// front/back pair. Depends on tgo_pkg, tgo_front, tgo_back (and tgo_ram).
//
//   Channel   Handshake                 Payload                 Transfer when
//   input     push / full               item   (tgo_pkg::in_t)  push && !full
//   result    pop / empty               result (tgo_pkg::out_t) pop && !empty
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data     cfg_valid && cfg_ready
//
// After reset the tile store is cleared one entry per cycle, all STORE_DEPTH
// (16384) entries, with full held high; config writes are still taken.
// A write item is applied to the store as it leaves the command queue. A query
// reads its covered tiles (span columns times span rows, at most 64) one per
// cycle through the single read port of the tile store, then finishes the last
// read and releases the final hit. The scan pauses while the result queue holds
// more than two hits; the two-entry command queue takes input meanwhile.
`default_nettype none

module tile_grid_overlap_scan (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input queue side
    input  wire logic                           push,
    output      logic                           full,
    input  wire tgo_pkg::in_t                   item,
    // result queue side
    output      logic                           empty,
    input  wire logic                           pop,
    output      tgo_pkg::out_t                  result,
    // configuration writes
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [tgo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tgo_pkg::CFG_W-1:0]      cfg_data
);

    logic [tgo_pkg::CFG_W-1:0] tiles_wide_reg, tiles_wide_next;
    logic [tgo_pkg::CFG_W-1:0] tiles_high_reg, tiles_high_next;
    tgo_pkg::cmd_t             cmd;
    logic                      cmd_valid;
    logic                      cmd_pop;
    logic                      clearing;

    // Configuration never stalls
    assign cfg_ready = 1'b1;

    // Decode the register index; unknown indexes drop the write
    always_comb
    begin
        tiles_wide_next = tiles_wide_reg;
        tiles_high_next = tiles_high_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tgo_pkg::REG_TILES_WIDE: tiles_wide_next = cfg_data;
                tgo_pkg::REG_TILES_HIGH: tiles_high_next = cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiles_wide_reg <= tgo_pkg::TILES_WIDE_RST;
            tiles_high_reg <= tgo_pkg::TILES_HIGH_RST;
        end
        else
        begin
            tiles_wide_reg <= tiles_wide_next;
            tiles_high_reg <= tiles_high_next;
        end
    end

    // Accept and classify items, queue commands
    tgo_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .clearing  (clearing),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // Clear the store, apply writes, scan queries, queue hits
    tgo_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .tiles_wide (tiles_wide_reg),
        .tiles_high (tiles_high_reg),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .clearing   (clearing),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for tile_grid_overlap_scan: tile writes and rectangle queries
// go in, tile hits come out and are checked against a predictor kept in this file.
// Depends on tgo_pkg and the tile_grid_overlap_scan RTL.

module tb_top;
    import tgo_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    // Quiet cycles after the last expected hit: covers a full command queue of
    // widest queries that find nothing, plus the result queue.
    localparam int SETTLE_CYCLES  = 300;
    localparam int DRAIN_LIMIT    = 50000;
    // Covers the clearing pass after reset (one entry per cycle), then every
    // item at its worst with the receiver stalling, several times over.
    localparam int TIMEOUT_CYCLES = 3_000_000;
    // Most random traffic lands in this corner of the grid so hits stay common.
    localparam int HOT_TILES      = 12;

    // The register index is two bits wide, but only two registers exist.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    typedef struct {
        in_t  it;
        int   n_typed;   // -1: take the hits from the predictor
        out_t want;      // used when n_typed is 1
    } plan_row_t;

    typedef struct {
        int wide;
        int high;
        int idle_pct;
        int stall_pct;
        int n_items;
    } phase_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    in_t                  item      = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    out_t                 result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int n_errors      = 0;

    // Predictor state: the tile store and the two grid-size registers.
    logic [CODE_W-1:0] tile_mem [NUM_LAYERS][GRID_ROWS][GRID_COLS];
    logic [CFG_W-1:0]  grid_wide = TILES_WIDE_RST;
    logic [CFG_W-1:0]  grid_high = TILES_HIGH_RST;

    // Hits still owed by the block, oldest first.
    out_t      hit_queue [$];
    plan_row_t plan [$];

    // Phases of the random part: grid sizes include zero, one, the full grid and
    // values above it; idling covers none, sender only, receiver only, and both.
    phase_t phases [7] = '{
        '{127, 127,  0,  0, 50},
        '{ 20,   9, 62,  0, 50},
        '{  1,   1,  0, 62, 40},
        '{  0,  64,  9,  9, 30},
        '{ 64,   0,  0,  0, 30},
        '{ 37,  50,  9,  9, 50},
        '{ 64,  64,  0, 62, 70}
    };

    tile_grid_overlap_scan u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Tiles covered by a size in pixels: round to the nearest tile, cap at MAX_SPAN.
    function automatic int span_tiles(input logic [SIZE_W-1:0] size);
        int s;
        s = (int'(size) + TILE_ROUND) >> TILE_SHIFT;
        return (s > MAX_SPAN) ? MAX_SPAN : s;
    endfunction

    // Apply one item to the predictor: a write updates the store, a query
    // returns its hits in scan order (rows top to bottom, columns left to right).
    function automatic void grid_step(input in_t it, ref out_t found[$]);
        int   cols_used;
        int   rows_used;
        int   x0;
        int   y0;
        int   sw;
        int   sh;
        out_t h;
        found.delete();
        if (it.action == ACT_WRITE)
        begin
            tile_mem[it.layer][it.tile_row][it.tile_col] = it.tile_code;
            return;
        end
        // Registers above the physical grid clamp to it; zero empties everything.
        cols_used = (int'(grid_wide) < GRID_COLS) ? int'(grid_wide) : GRID_COLS;
        rows_used = (int'(grid_high) < GRID_ROWS) ? int'(grid_high) : GRID_ROWS;
        x0 = int'(it.pos_x) >> TILE_SHIFT;
        y0 = int'(it.pos_y) >> TILE_SHIFT;
        sw = span_tiles(it.rect_width);
        sh = span_tiles(it.rect_height);
        for (int r = y0; r < y0 + sh; r++)
        begin
            if (r >= rows_used)
                continue;
            for (int c = x0; c < x0 + sw; c++)
            begin
                if (c >= cols_used || tile_mem[it.layer][r][c] == '0)
                    continue;
                if (found.size() >= MAX_SPAN * MAX_SPAN)
                    continue;
                h.hit_entity = it.entity;
                h.hit_code   = tile_mem[it.layer][r][c];
                h.hit_col    = TPOS_W'(c);
                h.hit_row    = TPOS_W'(r);
                h.last       = 1'b0;
                found.push_back(h);
            end
        end
        if (found.size() > 0)
            found[found.size() - 1].last = 1'b1;
    endfunction

    function automatic in_t mk_write(input int layer, input int col, input int row,
                                     input int code);
        in_t it;
        it           = '0;
        it.action    = ACT_WRITE;
        it.layer     = LAYER_W'(layer);
        it.tile_col  = TPOS_W'(col);
        it.tile_row  = TPOS_W'(row);
        it.tile_code = CODE_W'(code);
        return it;
    endfunction

    function automatic in_t mk_query(input int entity, input int layer, input int px,
                                     input int py, input int w, input int h);
        in_t it;
        it             = '0;
        it.action      = ACT_QUERY;
        it.entity      = ID_W'(entity);
        it.layer       = LAYER_W'(layer);
        it.pos_x       = POS_W'(px);
        it.pos_y       = POS_W'(py);
        it.rect_width  = SIZE_W'(w);
        it.rect_height = SIZE_W'(h);
        return it;
    endfunction

    // A single hit, which is therefore also the last one of its query.
    function automatic out_t one_hit(input int entity, input int code, input int col,
                                     input int row);
        out_t h;
        h.hit_entity = ID_W'(entity);
        h.hit_code   = CODE_W'(code);
        h.hit_col    = TPOS_W'(col);
        h.hit_row    = TPOS_W'(row);
        h.last       = 1'b1;
        return h;
    endfunction

    function automatic void add_row(input in_t it, input int n_typed, input out_t want);
        plan_row_t row;
        row.it      = it;
        row.n_typed = n_typed;
        row.want    = want;
        plan.push_back(row);
    endfunction

    // Random item: mostly writes and queries around the hot corner so queries
    // find tiles, with a share of fully random fields to reach every bit.
    function automatic in_t random_item();
        in_t it;
        it.action      = ($urandom_range(99) < 40) ? ACT_WRITE : ACT_QUERY;
        it.entity      = ID_W'($urandom);
        it.layer       = LAYER_W'($urandom);
        it.pos_x       = POS_W'($urandom);
        it.pos_y       = POS_W'($urandom);
        it.rect_width  = SIZE_W'($urandom);
        it.rect_height = SIZE_W'($urandom);
        it.tile_col    = TPOS_W'($urandom);
        it.tile_row    = TPOS_W'($urandom);
        it.tile_code   = CODE_W'($urandom);
        if (it.action == ACT_WRITE)
        begin
            if ($urandom_range(99) < 85)
            begin
                it.tile_col = TPOS_W'($urandom_range(HOT_TILES - 1));
                it.tile_row = TPOS_W'($urandom_range(HOT_TILES - 1));
            end
            // Some writes clear a tile again.
            if ($urandom_range(99) < 25)
                it.tile_code = '0;
        end
        else if ($urandom_range(99) < 85)
        begin
            it.pos_x = POS_W'($urandom_range(HOT_TILES * 8 - 1));
            it.pos_y = POS_W'($urandom_range(HOT_TILES * 8 - 1));
            if ($urandom_range(9) != 0)
            begin
                it.rect_width  = SIZE_W'($urandom_range(72));
                it.rect_height = SIZE_W'($urandom_range(72));
            end
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // Present one item from a falling edge, idling first at the sender's rate.
    // Hold push and the item until the transfer, then predict on acceptance.
    // Return at the next falling edge with push still high.
    task automatic send_item(input in_t it, input int n_typed, input out_t want);
        out_t found [$];
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        grid_step(it, found);
        if (n_typed < 0)
        begin
            foreach (found[k])
                hit_queue.push_back(found[k]);
        end
        else if (n_typed > 0)
        begin
            hit_queue.push_back(want);
        end
        @(negedge clk);
    endtask

    // One register transfer; cfg_valid stays high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_TILES_WIDE)
            grid_wide = val;
        else if (idx == REG_TILES_HIGH)
            grid_high = val;
        @(negedge clk);
    endtask

    // Set the grid in use; the spare indexes must change nothing.
    task automatic set_grid(input int wide, input int high);
        write_reg(REG_TILES_WIDE, CFG_W'(wide));
        write_reg(REG_TILES_HIGH, CFG_W'(high));
        write_reg(REG_SPARE_2, CFG_W'($urandom));
        write_reg(REG_SPARE_3, CFG_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Drop push, wait for every owed hit, then let trailing writes and empty
    // queries finish before the registers change.
    task automatic settle();
        push <= 1'b0;
        while (hit_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Receiver: decide pop at each falling edge at the current stall rate.
    always @(negedge clk)
        pop <= ($urandom_range(99) >= pop_stall_pct);

    // Check every result transfer against the oldest owed hit.
    always @(posedge clk)
    begin : check_hits
        out_t want;
        if (rst_n && pop && !empty)
        begin
            if (hit_queue.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result: expected none, got %h", $time, result);
            end
            else
            begin
                want = hit_queue.pop_front();
                check_field("hit_entity", want.hit_entity, result.hit_entity);
                check_field("hit_code", want.hit_code, result.hit_code);
                check_field("hit_col", want.hit_col, result.hit_col);
                check_field("hit_row", want.hit_row, result.hit_row);
                check_field("last", want.last, result.last);
            end
        end
    end

    initial
    begin : stimulus
        int drained;
        foreach (tile_mem[l, r, c])
            tile_mem[l][r][c] = '0;

        // Directed part, on the reset grid of 64 by 64.
        // Cleared store: a full 8x8 query finds nothing.
        add_row(mk_query(16'h0001, 0, 0, 0, 64, 64), 0, '0);
        add_row(mk_write(0, 0, 0, 8'hFF), 0, '0);
        add_row(mk_write(3, 63, 63, 8'h01), 0, '0);
        // Zero size, and a size that rounds down to zero tiles.
        add_row(mk_query(16'h1234, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_query(16'hBEEF, 0, 0, 0, 3, 3), 0, '0);
        // Smallest size that rounds up to one tile.
        add_row(mk_query(16'hBEEF, 0, 0, 0, 4, 4), 1, one_hit(16'hBEEF, 8'hFF, 0, 0));
        // Largest sizes clamp to the maximum span; the corner tile is the only hit.
        add_row(mk_query(16'hFFFF, 3, 504, 504, 16'hFFFF, 16'hFFFF), 1,
                one_hit(16'hFFFF, 8'h01, 63, 63));
        // Rectangle far beyond the grid sees only empty tiles.
        add_row(mk_query(16'h0000, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, '0);
        // Another layer is still empty.
        add_row(mk_query(16'h5555, 1, 0, 0, 64, 64), 0, '0);
        add_row(mk_write(0, 1, 0, 8'h10), 0, '0);
        add_row(mk_write(0, 0, 1, 8'h20), 0, '0);
        add_row(mk_write(0, 7, 7, 8'h80), 0, '0);
        // Just right of an 8-wide span starting at column zero.
        add_row(mk_write(0, 8, 0, 8'h33), -1, '0);
        add_row(mk_query(16'hA5A5, 0, 0, 0, 60, 60), -1, '0);
        add_row(mk_query(16'h0F0F, 0, 7, 7, 68, 4), -1, '0);
        // Writing code zero clears a tile.
        add_row(mk_write(0, 0, 0, 8'h00), 0, '0);
        add_row(mk_query(16'h00FF, 0, 0, 0, 12, 4), 1, one_hit(16'h00FF, 8'h10, 1, 0));
        add_row(mk_write(2, 63, 0, 8'hAA), 0, '0);
        add_row(mk_query(16'hC3C3, 2, 511, 7, 4, 4), 1, one_hit(16'hC3C3, 8'hAA, 63, 0));
        // Span running off the right edge of the grid.
        add_row(mk_query(16'h7777, 2, 496, 0, 20, 12), -1, '0);

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The first transfer waits out the clearing pass behind full.
        foreach (plan[i])
            send_item(plan[i].it, plan[i].n_typed, plan[i].want);

        foreach (phases[p])
        begin
            settle();
            set_grid(phases[p].wide, phases[p].high);
            send_idle_pct = phases[p].idle_pct;
            pop_stall_pct = phases[p].stall_pct;
            for (int i = 0; i < phases[p].n_items; i++)
            begin
                // Once, hold the sender until every owed hit has come out.
                if (p == 1 && i == phases[p].n_items / 2)
                begin
                    push <= 1'b0;
                    do
                        @(negedge clk);
                    while (hit_queue.size() != 0);
                end
                send_item(random_item(), -1, '0);
            end
        end

        push <= 1'b0;
        drained = 0;
        while (hit_queue.size() != 0 && drained < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drained++;
        end
        if (hit_queue.size() != 0)
        begin
            n_errors += hit_queue.size();
            $display("%0t: %0d hits never arrived: expected %h first, got nothing",
                     $time, hit_queue.size(), hit_queue[0]);
        end
        // Stray results after the last owed hit still count as errors.
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
